[rtl/btr_pkg.sv]
// Shared types, codes and constants of the block transfer receiver.
package btr_pkg;

  localparam int COUNT_BITS_DEF = 24;

  localparam int LINE_W  = 4;
  localparam int TYPE_W  = 8;
  localparam int PAY_W   = 56;
  localparam int MAX_W   = 24;
  localparam int RSP_W   = 3;
  localparam int CNT_W   = 3;
  localparam int CFG_A_W = 2;
  localparam int TOTAL_W = 32;

  localparam logic [CNT_W-1:0] PAGE_BYTES = 3'd7;

  localparam logic [TYPE_W-1:0] PT_SETUP  = 8'd1;
  localparam logic [TYPE_W-1:0] PT_DATA_A = 8'd3;
  localparam logic [TYPE_W-1:0] PT_DATA_B = 8'd4;

  localparam logic [RSP_W-1:0] RSP_NONE      = 3'd0;
  localparam logic [RSP_W-1:0] RSP_ABORT     = 3'd1;
  localparam logic [RSP_W-1:0] RSP_REQ_WHOLE = 3'd2;
  localparam logic [RSP_W-1:0] RSP_COMPLETE  = 3'd3;
  localparam logic [RSP_W-1:0] RSP_DUPLICATE = 3'd4;

  localparam logic [CFG_A_W-1:0] CFG_PROG_LINES = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_CONF_LINES = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_PROG_MAX   = 2'd2;
  localparam logic [CFG_A_W-1:0] CFG_CONF_MAX   = 2'd3;

  localparam logic [LINE_W-1:0] LINES_RST    = 4'd8;
  localparam logic [MAX_W-1:0]  PROG_MAX_RST = 24'd65536;
  localparam logic [MAX_W-1:0]  CONF_MAX_RST = 24'd4096;

  typedef struct packed {
    logic armed;
    logic expect_four;
  } btr_flags_t;

  // low n bytes set
  function automatic logic [PAY_W-1:0] byte_mask(input logic [CNT_W-1:0] n);
    logic [PAY_W-1:0] m;
    m = '0;
    for (int i = 0; i < PAY_W / 8; i++) begin
      m[8*i +: 8] = {8{(CNT_W'(i) < n)}};
    end
    return m;
  endfunction

endpackage

[rtl/btr_step.sv]
// Page decode, transfer state update and result forming for one page.
module btr_step import btr_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  kind,
  input  logic [LINE_W-1:0]     page_lines,
  input  logic [TYPE_W-1:0]     page_type,
  input  logic [PAY_W-1:0]      payload,
  input  logic [LINE_W-1:0]     prog_lines,
  input  logic [LINE_W-1:0]     conf_lines,
  input  logic [MAX_W-1:0]      prog_max,
  input  logic [MAX_W-1:0]      conf_max,
  input  btr_flags_t            flags,
  input  logic [COUNT_BITS-1:0] total,
  input  logic [COUNT_BITS-1:0] received,
  output btr_flags_t            flags_nxt,
  output logic [COUNT_BITS-1:0] total_nxt,
  output logic [COUNT_BITS-1:0] received_nxt,
  output logic [RSP_W-1:0]      response,
  output logic [PAY_W-1:0]      data_bytes,
  output logic [CNT_W-1:0]      data_count
);

  logic [LINE_W-1:0]     need_lines;
  logic [MAX_W-1:0]      max_bytes;
  logic                  bad_page;
  logic [TOTAL_W-1:0]    setup_total;
  logic                  too_big;
  logic [COUNT_BITS-1:0] remain;
  logic [CNT_W-1:0]      n;
  logic [COUNT_BITS-1:0] recv_sum;

  assign need_lines = kind ? conf_lines : prog_lines;
  assign max_bytes  = kind ? conf_max : prog_max;
  assign bad_page   = (page_lines != need_lines) ||
                      !((page_type == PT_SETUP) || (page_type == PT_DATA_A) ||
                        (page_type == PT_DATA_B));

  assign setup_total = payload[TOTAL_W-1:0];
  assign too_big     = (setup_total > TOTAL_W'(max_bytes)) ||
                       ((setup_total >> COUNT_BITS) != '0);

  assign remain   = (total >= received) ? (total - received) : '0;
  assign n        = (remain >= COUNT_BITS'(PAGE_BYTES)) ? PAGE_BYTES : remain[CNT_W-1:0];
  assign recv_sum = received + COUNT_BITS'(n);

  always_comb begin
    flags_nxt    = flags;
    total_nxt    = total;
    received_nxt = received;
    response     = RSP_NONE;
    data_bytes   = '0;
    data_count   = '0;
    priority if (bad_page) begin
      flags_nxt.armed = 1'b0;
      response        = RSP_ABORT;
    end else if (page_type == PT_SETUP) begin
      if (too_big) begin
        flags_nxt.armed = 1'b0;
        response        = RSP_ABORT;
      end else begin
        total_nxt             = setup_total[COUNT_BITS-1:0];
        received_nxt          = '0;
        flags_nxt.expect_four = 1'b0;
        flags_nxt.armed       = 1'b1;
        response              = RSP_REQ_WHOLE;
      end
    end else if (!flags.armed) begin
      response = RSP_ABORT;
    end else if ((page_type == PT_DATA_B) != flags.expect_four) begin
      response = RSP_DUPLICATE;
    end else begin
      flags_nxt.expect_four = !flags.expect_four;
      data_bytes            = payload & byte_mask(n);
      data_count            = n;
      received_nxt          = recv_sum;
      if (recv_sum >= total) begin
        flags_nxt.armed = 1'b0;
        response        = RSP_COMPLETE;
      end
    end
  end

endmodule

[rtl/block_transfer_receiver.sv]
// Top level of the block transfer receiver: beat registers, config and state.
//
// One page beat in, one result beat out. A page is taken in every cycle while
// results drain; each result passes through one input register and one result
// register around a single decode stage. in_tready drops only while both
// registers hold beats and out_tready is low. Setup pages arm a transfer of
// up to the configured byte maximum, data pages of types 3 and 4 must
// alternate and pass at most 7 bytes each.
module block_transfer_receiver import btr_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [71:0]        in_tdata,  // lines, page_type, payload, zero fill
  input  logic               in_tuser,  // kind
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [63:0]        out_tdata, // response, data_bytes, data_count, zero fill
  output logic               out_tuser, // reply_kind
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [MAX_W-1:0]   cfg_wdata
);

  logic [LINE_W-1:0] prog_lines_r;
  logic [LINE_W-1:0] conf_lines_r;
  logic [MAX_W-1:0]  prog_max_r;
  logic [MAX_W-1:0]  conf_max_r;

  logic              ib_valid_r;
  logic              ib_kind_r;
  logic [LINE_W-1:0] ib_lines_r;
  logic [TYPE_W-1:0] ib_type_r;
  logic [PAY_W-1:0]  ib_payload_r;

  btr_flags_t            flags_r;
  btr_flags_t            flags_nxt;
  logic [COUNT_BITS-1:0] total_r;
  logic [COUNT_BITS-1:0] total_nxt;
  logic [COUNT_BITS-1:0] recv_r;
  logic [COUNT_BITS-1:0] recv_nxt;

  logic [RSP_W-1:0] rsp_nxt;
  logic [PAY_W-1:0] data_nxt;
  logic [CNT_W-1:0] count_nxt;

  logic             ob_valid_r;
  logic             ob_kind_r;
  logic [RSP_W-1:0] ob_rsp_r;
  logic [PAY_W-1:0] ob_data_r;
  logic [CNT_W-1:0] ob_count_r;

  logic advance;

  assign advance   = !ob_valid_r || out_tready;
  assign in_tready = !ib_valid_r || advance;

  btr_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .kind         (ib_kind_r),
    .page_lines   (ib_lines_r),
    .page_type    (ib_type_r),
    .payload      (ib_payload_r),
    .prog_lines   (prog_lines_r),
    .conf_lines   (conf_lines_r),
    .prog_max     (prog_max_r),
    .conf_max     (conf_max_r),
    .flags        (flags_r),
    .total        (total_r),
    .received     (recv_r),
    .flags_nxt    (flags_nxt),
    .total_nxt    (total_nxt),
    .received_nxt (recv_nxt),
    .response     (rsp_nxt),
    .data_bytes   (data_nxt),
    .data_count   (count_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_lines_r <= LINES_RST;
      conf_lines_r <= LINES_RST;
      prog_max_r   <= PROG_MAX_RST;
      conf_max_r   <= CONF_MAX_RST;
      ib_valid_r   <= 1'b0;
      ob_valid_r   <= 1'b0;
      flags_r      <= '0;
      total_r      <= '0;
      recv_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_PROG_LINES: prog_lines_r <= cfg_wdata[LINE_W-1:0];
          CFG_CONF_LINES: conf_lines_r <= cfg_wdata[LINE_W-1:0];
          CFG_PROG_MAX:   prog_max_r   <= cfg_wdata;
          CFG_CONF_MAX:   conf_max_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_tready) begin
        ib_valid_r <= in_tvalid;
      end
      if (advance) begin
        ob_valid_r <= ib_valid_r;
      end
      if (advance && ib_valid_r) begin
        flags_r <= flags_nxt;
        total_r <= total_nxt;
        recv_r  <= recv_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ib_kind_r    <= in_tuser;
      ib_lines_r   <= in_tdata[3:0];
      ib_type_r    <= in_tdata[11:4];
      ib_payload_r <= in_tdata[67:12];
    end
    if (advance && ib_valid_r) begin
      ob_kind_r  <= ib_kind_r;
      ob_rsp_r   <= rsp_nxt;
      ob_data_r  <= data_nxt;
      ob_count_r <= count_nxt;
    end
  end

  assign out_tvalid = ob_valid_r;
  assign out_tuser  = ob_kind_r;
  assign out_tdata  = {2'b00, ob_count_r, ob_data_r, ob_rsp_r};

`ifndef ASSERT_OFF
  a_recv_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.armed |-> (recv_r <= total_r))
    else $error("received count past transfer total while armed");

  a_data_only_on_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (ob_valid_r && (ob_count_r != '0)) |->
      ((ob_rsp_r == RSP_NONE) || (ob_rsp_r == RSP_COMPLETE)))
    else $error("data bytes on a non-data response");

  a_data_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    ob_valid_r |-> ((ob_data_r & ~byte_mask(ob_count_r)) == '0))
    else $error("data bytes above data count not zero");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (ib_valid_r && ob_valid_r && !out_tready))
    else $error("input stalled with room in the pipeline");

  a_complete_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && ib_valid_r && (rsp_nxt == RSP_COMPLETE)) |=> !flags_r.armed)
    else $error("transfer still armed after completion");
`endif

endmodule
